FILE: rtl/ght_pkg.sv
`timescale 1ns / 1ps

package ght_pkg;

  // Defaults for the top-level parameters
  localparam int SLOTS_DEF        = 1024;
  localparam int FIRST_CAP_DEF    = 32;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Field widths
  localparam int ACT_W    = 3;
  localparam int KIND_W   = 4;
  localparam int GEN_W    = 11;
  localparam int IDX_W    = 16;
  localparam int HDL_W    = 32;
  localparam int HOUT_W   = 31;
  localparam int PAY_W    = 32;
  localparam int CNT_W    = 16;
  localparam int STAT_W   = 3;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RESOLVE    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CLOSE      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLOSE_KIND = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLOSE_ALL  = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_KIND = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_BAD      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_STALE    = 3'd4;
  localparam logic [STAT_W-1:0] STAT_WRONG    = 3'd5;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_CK,
    S_HDL_CK,
    S_KIND_RD,
    S_KIND_CK,
    S_SWEEP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [HDL_W-1:0]  handle;
    logic [KIND_W-1:0]        kind;
    logic [PAY_W-1:0]         payload;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [HOUT_W-1:0] handle_out;
    logic [KIND_W-1:0] kind_out;
    logic [PAY_W-1:0]  payload_out;
    logic [CNT_W-1:0]  count;
  } rsp_t;

  // Generation advance: wraps past 0x7FF to 1, never 0
  function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + 1'b1;
    return (n == '0) ? GEN_W'(1) : n;
  endfunction

endpackage

FILE: rtl/ght_req_if.sv
`timescale 1ns / 1ps

interface ght_req_if;
  logic          valid;
  logic          ready;
  ght_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ght_rsp_if.sv
`timescale 1ns / 1ps

interface ght_rsp_if;
  logic          valid;
  logic          ready;
  ght_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ght_slot_mem.sv
`timescale 1ns / 1ps

// Slot store: one write port, one read port, registered read data.
// Word layout: {kind, generation, payload}.
module ght_slot_mem #(
  parameter int DEPTH = ght_pkg::SLOTS_DEF,
  parameter int AW    = $clog2(ght_pkg::SLOTS_DEF),
  parameter int PW    = ght_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [ght_pkg::KIND_W-1:0]  wkind,
  input  logic [ght_pkg::GEN_W-1:0]   wgen,
  input  logic [PW-1:0]               wpay,
  input  logic [AW-1:0]               raddr,
  output logic [ght_pkg::KIND_W-1:0]  rkind,
  output logic [ght_pkg::GEN_W-1:0]   rgen,
  output logic [PW-1:0]               rpay
);

  localparam int WW = ght_pkg::KIND_W + ght_pkg::GEN_W + PW;

  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rword;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wkind, wgen, wpay};
    end
  end

  always_ff @(posedge clk) begin
    rword <= mem[raddr];
  end

  assign rkind = rword[WW-1 -: ght_pkg::KIND_W];
  assign rgen  = rword[PW +: ght_pkg::GEN_W];
  assign rpay  = rword[PW-1:0];

endmodule

FILE: rtl/generational_handle_table_unit.sv
`timescale 1ns / 1ps

// Generational handle table.
// req (sink): one transaction per action: allocate, resolve, close,
//   close by kind, close all. rsp (source): exactly one result transaction
//   per request, in order.
// The slot state lives in one single-port-read, single-port-write memory
// with registered read data; allocate, close and close by kind are
// read-modify-write sequences over it, resolve only reads and close all
// only writes, one action at a time. Steps, request accepted to result:
//   resolve / close with a handle that passes the range check: slot read, check.
//   invalid handle, allocate of kind 0, unknown action: no slot access.
//   allocate: slots read and checked from index 1 up to the first free
//     slot, plus a table growth step each time the scan reaches capacity.
//   close by kind: each slot from index 1 below capacity read and checked.
//   close all: every slot below capacity written, then capacity cleared.
// req.ready is high only while the sequencer is idle; a new request can be
// taken while the previous result still waits in the output register.
// Reset: a clearing pass writes every slot, one per cycle,
// with req.ready low. When rsp.ready is low the finished result holds in
// the output register and the next result waits in its own state.
module generational_handle_table_unit #(
  parameter int SLOTS          = ght_pkg::SLOTS_DEF,
  parameter int FIRST_CAPACITY = ght_pkg::FIRST_CAP_DEF,
  parameter int PAYLOAD_BITS   = ght_pkg::PAYLOAD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  ght_req_if.sink           req,
  ght_rsp_if.source         rsp
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = AW + 1;
  localparam int SW = (PAYLOAD_BITS < ght_pkg::PAY_W) ? PAYLOAD_BITS : ght_pkg::PAY_W;
  localparam int FIRST = (FIRST_CAPACITY > SLOTS) ? SLOTS : FIRST_CAPACITY;
  localparam logic [CW-1:0] FIRST_C = CW'(FIRST);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  localparam logic [CW-1:0] LAST_C  = CW'(SLOTS - 1);

  ght_pkg::state_t state, state_next;

  logic [CW-1:0]                   cap, cap_next;
  logic [CW-1:0]                   idx, idx_next;
  logic [ght_pkg::CNT_W-1:0]       cnt, cnt_next;
  logic [ght_pkg::ACT_W-1:0]       act, act_next;
  logic [ght_pkg::HDL_W-1:0]       hdl, hdl_next;
  logic [ght_pkg::KIND_W-1:0]      kind, kind_next;
  logic [SW-1:0]                   pay, pay_next;
  ght_pkg::rsp_t                   pend, pend_next;
  ght_pkg::rsp_t                   out_data;
  logic                            out_valid;
  logic                            out_load;

  // Memory ports
  logic                            we;
  logic [AW-1:0]                   waddr, raddr;
  logic [ght_pkg::KIND_W-1:0]      wkind, rkind;
  logic [ght_pkg::GEN_W-1:0]       wgen, rgen;
  logic [SW-1:0]                   wpay, rpay;

  // Handle decode of the incoming request
  logic [ght_pkg::HDL_W-1:0]       req_h;
  logic [ght_pkg::IDX_W-1:0]       req_idx;
  logic                            req_bad;
  assign req_h   = req.data.handle;
  assign req_idx = req_h[ght_pkg::IDX_W-1:0];
  assign req_bad = (req_h == '0) || req_h[ght_pkg::HDL_W-1] || (req_idx == '0)
                   || ({1'b0, req_idx} >= (ght_pkg::IDX_W+1)'(cap));

  // Fields of the registered handle
  logic [ght_pkg::GEN_W-1:0]       h_gen;
  logic [ght_pkg::KIND_W-1:0]      h_kind;
  assign h_gen  = hdl[ght_pkg::IDX_W +: ght_pkg::GEN_W];
  assign h_kind = hdl[27 +: ght_pkg::KIND_W];

  // Growth step: double, capped at SLOTS
  logic [CW:0]                     dbl;
  logic [CW-1:0]                   want;
  assign dbl  = {cap, 1'b0};
  assign want = (dbl > (CW+1)'(SLOTS)) ? SLOTS_C : dbl[CW-1:0];

  assign req.ready = (state == ght_pkg::S_IDLE);
  assign out_load  = (state == ght_pkg::S_DONE) && (!out_valid || rsp.ready);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  ght_slot_mem #(.DEPTH(SLOTS), .AW(AW), .PW(SW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wkind (wkind),
    .wgen  (wgen),
    .wpay  (wpay),
    .raddr (raddr),
    .rkind (rkind),
    .rgen  (rgen),
    .rpay  (rpay)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ght_pkg::S_CLEAR: begin
        if (idx == LAST_C) state_next = ght_pkg::S_IDLE;
      end
      ght_pkg::S_IDLE: begin
        if (req.valid) begin
          case (req.data.action)
            ght_pkg::ACT_ALLOC:
              state_next = (req.data.kind == '0) ? ght_pkg::S_DONE : ght_pkg::S_ALLOC_RD;
            ght_pkg::ACT_RESOLVE, ght_pkg::ACT_CLOSE:
              state_next = req_bad ? ght_pkg::S_DONE : ght_pkg::S_HDL_CK;
            ght_pkg::ACT_CLOSE_KIND: state_next = ght_pkg::S_KIND_RD;
            ght_pkg::ACT_CLOSE_ALL:  state_next = ght_pkg::S_SWEEP;
            default:                 state_next = ght_pkg::S_DONE;
          endcase
        end
      end
      ght_pkg::S_ALLOC_RD: begin
        if (idx < cap) state_next = ght_pkg::S_ALLOC_CK;
        else if (want <= cap) state_next = ght_pkg::S_DONE;
      end
      ght_pkg::S_ALLOC_CK: begin
        state_next = (rkind == '0) ? ght_pkg::S_DONE : ght_pkg::S_ALLOC_RD;
      end
      ght_pkg::S_HDL_CK:   state_next = ght_pkg::S_DONE;
      ght_pkg::S_KIND_RD: begin
        state_next = (idx < cap) ? ght_pkg::S_KIND_CK : ght_pkg::S_DONE;
      end
      ght_pkg::S_KIND_CK:  state_next = ght_pkg::S_KIND_RD;
      ght_pkg::S_SWEEP: begin
        if (idx >= cap) state_next = ght_pkg::S_DONE;
      end
      ght_pkg::S_DONE: begin
        if (out_load) state_next = ght_pkg::S_IDLE;
      end
      default: state_next = ght_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cap_next  = cap;
    idx_next  = idx;
    cnt_next  = cnt;
    act_next  = act;
    hdl_next  = hdl;
    kind_next = kind;
    pay_next  = pay;
    pend_next = pend;
    we        = 1'b0;
    waddr     = idx[AW-1:0];
    wkind     = '0;
    wgen      = ght_pkg::GEN_W'(1);
    wpay      = '0;
    raddr     = idx[AW-1:0];
    case (state)
      ght_pkg::S_CLEAR: begin
        we       = 1'b1;
        idx_next = idx + 1'b1;
      end
      ght_pkg::S_IDLE: begin
        raddr = req_idx[AW-1:0];
        if (req.valid) begin
          act_next  = req.data.action;
          hdl_next  = req_h;
          kind_next = req.data.kind;
          pay_next  = req.data.payload[SW-1:0];
          pend_next = '0;
          idx_next  = CW'(1);
          cnt_next  = '0;
          case (req.data.action)
            ght_pkg::ACT_ALLOC: begin
              if (req.data.kind == '0) pend_next.status = ght_pkg::STAT_BAD_KIND;
              else if (cap == '0) cap_next = FIRST_C;
            end
            ght_pkg::ACT_RESOLVE, ght_pkg::ACT_CLOSE: begin
              if (req_bad) pend_next.status = ght_pkg::STAT_BAD;
              idx_next = CW'(req_idx);
            end
            ght_pkg::ACT_CLOSE_ALL: idx_next = '0;
            default: ;
          endcase
        end
      end
      ght_pkg::S_ALLOC_RD: begin
        if (idx >= cap) begin
          if (want <= cap) pend_next.status = ght_pkg::STAT_FULL;
          else cap_next = want;
        end
      end
      ght_pkg::S_ALLOC_CK: begin
        if (rkind == '0) begin
          we    = 1'b1;
          wkind = kind;
          wgen  = rgen;
          wpay  = pay;
          pend_next.handle_out = {kind, rgen, ght_pkg::IDX_W'(idx)};
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ght_pkg::S_HDL_CK: begin
        if (rkind == '0 || rgen != h_gen) begin
          pend_next.status = ght_pkg::STAT_STALE;
        end else if (h_kind != rkind || (kind != '0 && rkind != kind)) begin
          pend_next.status = ght_pkg::STAT_WRONG;
        end else begin
          pend_next.kind_out    = rkind;
          pend_next.payload_out = ght_pkg::PAY_W'(rpay);
          if (act == ght_pkg::ACT_CLOSE) begin
            we   = 1'b1;
            wgen = ght_pkg::next_gen(rgen);
          end
        end
      end
      ght_pkg::S_KIND_RD: begin
        if (idx >= cap) pend_next.count = cnt;
      end
      ght_pkg::S_KIND_CK: begin
        if (rkind == kind) begin
          we       = 1'b1;
          wgen     = ght_pkg::next_gen(rgen);
          cnt_next = cnt + 1'b1;
        end
        idx_next = idx + 1'b1;
      end
      ght_pkg::S_SWEEP: begin
        if (idx >= cap) begin
          cap_next = '0;
        end else begin
          we       = 1'b1;
          idx_next = idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ght_pkg::S_CLEAR;
      cap       <= '0;
      idx       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cap   <= cap_next;
      idx   <= idx_next;
      cnt   <= cnt_next;
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act  <= act_next;
    hdl  <= hdl_next;
    kind <= kind_next;
    pay  <= pay_next;
    pend <= pend_next;
    if (out_load) out_data <= pend;
  end

endmodule
